[sv/greedy_activity_selector_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the greedy activity selector
// Concurrent checks that are compiled in simulation and left out in synthesis.
// ----------------------------------------------------------------------------
`ifndef GREEDY_ACTIVITY_SELECTOR_ASSERT_SVH
`define GREEDY_ACTIVITY_SELECTOR_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is asserted
`define GAS_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
    else $error("gas assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define GAS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
    else $error("gas assertion failed");

`else

`define GAS_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs)
`define GAS_ASSERT_NEXT(label, clk, rst_n, lhs, rhs)

`endif

`endif

[sv/gas_pkg.sv]
// ----------------------------------------------------------------------------
// Greedy activity selector package
// Sizes and shared types for the store, the sequencer and the top level.
// ----------------------------------------------------------------------------
package gas_pkg;

  localparam int MAX_ACTIVITIES = 16;
  localparam int IDX_W          = $clog2(MAX_ACTIVITIES);
  localparam int CNT_W          = $clog2(MAX_ACTIVITIES + 1);
  localparam int ID_W           = 16;
  localparam int TIME_W         = 16;

  // One stored activity
  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] start;
    logic [TIME_W-1:0] finish;
  } entry_t;

  // Store access from the sequencer: one write and one read address per cycle
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    entry_t           wdata;
    logic [IDX_W-1:0] raddr;
  } mem_req_t;

  // Result beat handed to the output register
  typedef struct packed {
    logic            valid;
    logic [ID_W-1:0] id;
    logic            overflow;
    logic            last;
  } emit_t;

endpackage

[sv/greedy_activity_selector.sv]
// ----------------------------------------------------------------------------
// Greedy activity selector, top level
// Loads activities, sorts them by finish time and streams the chosen ids.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry one activity each: in_tdata holds id, start and finish,
//   in_tlast closes the set. Up to 16 activities are stored; further beats of
//   the same set are dropped and the results of that set carry out_tuser = 1.
//   Loading takes one cycle per beat and in_tready stays high while loading.
//   After the closing beat the block is busy: the selection sort reads the
//   store once per compare through its single read port, then the selection
//   scan reads each stored activity in turn, pushes each chosen id after the
//   first to the output and flushes the last one. No new set is taken until
//   the last id of the current set has been handed to the output register.
//   Chosen ids leave through a registered output, one beat each, in finish
//   order; out_tlast marks the final id of the set. When the receiver stalls
//   the scan waits on the output register and nothing is lost.
//   Reset clears the fill count, the drop flag and the sequencer; the store
//   contents are not cleared and are only used below the fill count.
// ----------------------------------------------------------------------------
`include "greedy_activity_selector_assert.svh"

module greedy_activity_selector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] activity_id, [31:16] start_time,
                                  // [47:32] finish_time
  input  logic        in_tlast,   // last_item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] chosen_id
  output logic        out_tuser,  // [0] overflow
  output logic        out_tlast   // last_result
);

  gas_pkg::entry_t   in_entry;
  gas_pkg::mem_req_t mem_req;
  gas_pkg::entry_t   rd_data;
  gas_pkg::emit_t    emit;
  logic              slot_free;

  logic                     out_valid_r;
  logic [gas_pkg::ID_W-1:0] out_id_r;
  logic                     out_ovf_r;
  logic                     out_last_r;

  // Unpack the input beat
  assign in_entry.id     = in_tdata[15:0];
  assign in_entry.start  = in_tdata[31:16];
  assign in_entry.finish = in_tdata[47:32];

  gas_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  gas_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_entry  (in_entry),
    .in_last   (in_tlast),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .slot_free (slot_free),
    .emit      (emit)
  );

  // Output slot is free when empty or being taken this cycle
  assign slot_free = !out_valid_r || out_tready;

  // Hold the result beat until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.valid) begin
      out_id_r   <= emit.id;
      out_ovf_r  <= emit.overflow;
      out_last_r <= emit.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_id_r;
  assign out_tuser  = out_ovf_r;
  assign out_tlast  = out_last_r;

  // Closing beat makes the block busy on the next cycle
  `GAS_ASSERT_NEXT(a_busy_after_last, clk, rst_n, in_tvalid && in_tready && in_tlast, !in_tready)
  // Sequencer never overwrites a beat still waiting in the output register
  `GAS_ASSERT_IMPLY(a_emit_into_free, clk, rst_n, emit.valid, slot_free)
  // No result is produced while activities are being loaded
  `GAS_ASSERT_IMPLY(a_no_emit_loading, clk, rst_n, in_tready, !emit.valid)

endmodule

[sv/gas_store.sv]
// ----------------------------------------------------------------------------
// Activity store
// Single write port, single registered read port holding id, start, finish.
// ----------------------------------------------------------------------------
module gas_store (
  input  logic              clk,
  input  gas_pkg::mem_req_t req,
  output gas_pkg::entry_t   rd_data
);

  gas_pkg::entry_t mem_r [gas_pkg::MAX_ACTIVITIES];
  gas_pkg::entry_t rd_data_r;

  // Write and read, read data registered
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem_r[req.waddr] <= req.wdata;
    end
    rd_data_r <= mem_r[req.raddr];
  end

  assign rd_data = rd_data_r;

endmodule

[sv/gas_ctrl.sv]
// ----------------------------------------------------------------------------
// Sequencer for load, sort and greedy selection
// Drives the store through its single read port: selection sort by finish
// time with swaps, then a scan that picks compatible activities in order.
// ----------------------------------------------------------------------------
module gas_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  gas_pkg::entry_t   in_entry,
  input  logic              in_last,
  output gas_pkg::mem_req_t mem_req,
  input  gas_pkg::entry_t   rd_data,
  input  logic              slot_free,
  output gas_pkg::emit_t    emit
);

  typedef enum logic [9:0] {
    ST_LOAD       = 10'b00_0000_0001,
    ST_SORT_RD    = 10'b00_0000_0010,
    ST_SORT_FIRST = 10'b00_0000_0100,
    ST_SCAN       = 10'b00_0000_1000,
    ST_SWAP_A     = 10'b00_0001_0000,
    ST_SWAP_B     = 10'b00_0010_0000,
    ST_SEL_RD     = 10'b00_0100_0000,
    ST_SEL_CHK    = 10'b00_1000_0000,
    ST_SEL_PUSH   = 10'b01_0000_0000,
    ST_SEL_FLUSH  = 10'b10_0000_0000
  } state_t;

  localparam int CNT_W = gas_pkg::CNT_W;
  localparam int IDX_W = gas_pkg::IDX_W;

  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             count_r, count_nxt;
  logic                         dropped_r, dropped_nxt;
  logic [IDX_W-1:0]             i_r, i_nxt;
  logic [IDX_W-1:0]             j_r, j_nxt;
  logic [IDX_W-1:0]             loc_r, loc_nxt;
  logic [IDX_W-1:0]             k_r, k_nxt;
  gas_pkg::entry_t              cur_r, cur_nxt;
  gas_pkg::entry_t              best_r, best_nxt;
  logic [gas_pkg::ID_W-1:0]     pend_id_r, pend_id_nxt;
  logic [gas_pkg::TIME_W-1:0]   last_fin_r, last_fin_nxt;
  logic [gas_pkg::ID_W-1:0]     cand_id_r, cand_id_nxt;
  logic [gas_pkg::TIME_W-1:0]   cand_fin_r, cand_fin_nxt;

  logic   j_more;
  logic   i_more;
  logic   k_more;
  state_t sel_adv_state;

  // Loop bounds against the set size
  assign j_more = (CNT_W'(j_r) + CNT_W'(1)) < count_r;
  assign i_more = (CNT_W'(i_r) + CNT_W'(2)) < count_r;
  assign k_more = (CNT_W'(k_r) + CNT_W'(1)) < count_r;
  assign sel_adv_state = k_more ? ST_SEL_RD : ST_SEL_FLUSH;

  assign in_tready = (state_r == ST_LOAD);

  // Sequence the store and the compare path
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    dropped_nxt   = dropped_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    loc_nxt       = loc_r;
    k_nxt         = k_r;
    cur_nxt       = cur_r;
    best_nxt      = best_r;
    pend_id_nxt   = pend_id_r;
    last_fin_nxt  = last_fin_r;
    cand_id_nxt   = cand_id_r;
    cand_fin_nxt  = cand_fin_r;
    mem_req.we    = 1'b0;
    mem_req.waddr = count_r[IDX_W-1:0];
    mem_req.wdata = in_entry;
    mem_req.raddr = i_r;
    emit.valid    = 1'b0;
    emit.id       = pend_id_r;
    emit.overflow = dropped_r;
    emit.last     = 1'b0;

    unique case (state_r)
      ST_LOAD: begin
        if (in_tvalid) begin
          if (count_r < CNT_W'(gas_pkg::MAX_ACTIVITIES)) begin
            mem_req.we = 1'b1;
            count_nxt  = count_r + CNT_W'(1);
          end else begin
            dropped_nxt = 1'b1;
          end
          if (in_last) begin
            i_nxt     = '0;
            k_nxt     = '0;
            state_nxt = (count_nxt > CNT_W'(1)) ? ST_SORT_RD : ST_SEL_RD;
          end
        end
      end
      ST_SORT_RD: begin
        mem_req.raddr = i_r;
        state_nxt     = ST_SORT_FIRST;
      end
      ST_SORT_FIRST: begin
        cur_nxt       = rd_data;
        best_nxt      = rd_data;
        loc_nxt       = i_r;
        j_nxt         = i_r + IDX_W'(1);
        mem_req.raddr = i_r + IDX_W'(1);
        state_nxt     = ST_SCAN;
      end
      ST_SCAN: begin
        // Keep the first minimum: replace only on strictly smaller finish
        if (rd_data.finish < best_r.finish) begin
          best_nxt = rd_data;
          loc_nxt  = j_r;
        end
        mem_req.raddr = j_r + IDX_W'(1);
        if (j_more) begin
          j_nxt = j_r + IDX_W'(1);
        end else begin
          state_nxt = ST_SWAP_A;
        end
      end
      ST_SWAP_A: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = i_r;
        mem_req.wdata = best_r;
        state_nxt     = ST_SWAP_B;
      end
      ST_SWAP_B: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = loc_r;
        mem_req.wdata = cur_r;
        if (i_more) begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = ST_SORT_RD;
        end else begin
          k_nxt     = '0;
          state_nxt = ST_SEL_RD;
        end
      end
      ST_SEL_RD: begin
        mem_req.raddr = k_r;
        state_nxt     = ST_SEL_CHK;
      end
      ST_SEL_CHK: begin
        cand_id_nxt  = rd_data.id;
        cand_fin_nxt = rd_data.finish;
        if (k_r == '0) begin
          // First sorted activity is always taken
          pend_id_nxt  = rd_data.id;
          last_fin_nxt = rd_data.finish;
          k_nxt        = k_r + IDX_W'(1);
          state_nxt    = sel_adv_state;
        end else if (rd_data.start >= last_fin_r) begin
          state_nxt = ST_SEL_PUSH;
        end else begin
          k_nxt     = k_r + IDX_W'(1);
          state_nxt = sel_adv_state;
        end
      end
      ST_SEL_PUSH: begin
        // Release the held pick now that a later one exists
        if (slot_free) begin
          emit.valid   = 1'b1;
          pend_id_nxt  = cand_id_r;
          last_fin_nxt = cand_fin_r;
          k_nxt        = k_r + IDX_W'(1);
          state_nxt    = sel_adv_state;
        end
      end
      ST_SEL_FLUSH: begin
        if (slot_free) begin
          emit.valid  = 1'b1;
          emit.last   = 1'b1;
          count_nxt   = '0;
          dropped_nxt = 1'b0;
          state_nxt   = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      loc_r     <= '0;
      k_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
      i_r       <= i_nxt;
      j_r       <= j_nxt;
      loc_r     <= loc_nxt;
      k_r       <= k_nxt;
    end
  end

  // Payload holding registers
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    best_r     <= best_nxt;
    pend_id_r  <= pend_id_nxt;
    last_fin_r <= last_fin_nxt;
    cand_id_r  <= cand_id_nxt;
    cand_fin_r <= cand_fin_nxt;
  end

endmodule
